[src/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types for the priority ready queue: action and status codes,
// controller states and the command/status bundles between its modules.
// ----------------------------------------------------------------------------
package prq_pkg;

    typedef enum logic [0:0] {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation chosen by the controller for the latched item
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FULL   = 2'd2,
        OP_EMPTY  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic latch;   // capture input beat
        logic exec;    // apply op and load result register
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic deq;     // latched beat is a dequeue
    } t_dp_sts;

endpackage

[src/prq_if.sv]
// ----------------------------------------------------------------------------
// prq_if
// Valid/ready stream interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface prq_in_if #(
    parameter int ID_W   = 8,
    parameter int PRIO_W = 8
);
    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;

    modport source (output valid, action, proc_id, prio, input ready);
    modport sink   (input valid, action, proc_id, prio, output ready);
endinterface

interface prq_out_if #(
    parameter int ID_W   = 8,
    parameter int PRIO_W = 8,
    parameter int CNT_W  = 5
);
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_prio;
    logic [1:0]        status;
    logic [CNT_W-1:0]  occupancy;

    modport source (output valid, out_id, out_prio, status, occupancy, input ready);
    modport sink   (input valid, out_id, out_prio, status, occupancy, output ready);
endinterface

[src/prq_ctrl.sv]
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: latches one beat, picks the operation from queue status and
// loads the result register once it is free or draining.
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_exec;

    assign w_exec = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '{latch: 1'b0, exec: 1'b0, op: OP_INSERT};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = w_exec;
            end
            default: ;
        endcase
        if (i_sts.deq) o_cmd.op = i_sts.empty ? OP_EMPTY : OP_REMOVE;
        else           o_cmd.op = i_sts.full  ? OP_FULL  : OP_INSERT;
    end

    assign n_out_valid = w_exec || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_valid)
        else $error("result not held after exec");
    a_idle_no_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.exec)
        else $error("exec issued while idle");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten");

endmodule

[src/prq_datapath.sv]
// ----------------------------------------------------------------------------
// prq_datapath
// Sorted slot row with per-slot compare, parallel insert/remove shift,
// entry count and result register.
// ----------------------------------------------------------------------------
module prq_datapath import prq_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ID_W   = 8,
    parameter int PRIO_W = 8,
    parameter int CNT_W  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_action,
    input  logic [ID_W-1:0]   i_proc_id,
    input  logic [PRIO_W-1:0] i_prio,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [ID_W-1:0]   o_out_id,
    output logic [PRIO_W-1:0] o_out_prio,
    output t_status           o_status,
    output logic [CNT_W-1:0]  o_occupancy
);

    logic [ID_W-1:0]   r_slot_id   [DEPTH];
    logic [PRIO_W-1:0] r_slot_prio [DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_act;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [DEPTH-1:0]  w_lower;     // slot empty or below new priority
    logic              w_ins, w_rem;

    assign o_sts.full  = (r_count == CNT_W'(DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_sts.deq   = (r_act == ACT_DEQ);

    assign w_ins = i_cmd.exec && (i_cmd.op == OP_INSERT);
    assign w_rem = i_cmd.exec && (i_cmd.op == OP_REMOVE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act  <= i_action;
            r_id   <= i_proc_id;
            r_prio <= i_prio;
        end
    end

    // sorted descending, so w_lower is monotonic: insert at its first set bit
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        assign w_lower[g] = (CNT_W'(g) >= r_count) || (r_slot_prio[g] < r_prio);

        always_ff @(posedge i_clk) begin
            if (w_ins && w_lower[g]) begin
                if (g == 0) begin
                    r_slot_id[g]   <= r_id;
                    r_slot_prio[g] <= r_prio;
                end else if (!w_lower[(g == 0) ? 0 : g-1]) begin
                    r_slot_id[g]   <= r_id;
                    r_slot_prio[g] <= r_prio;
                end else begin
                    r_slot_id[g]   <= r_slot_id[(g == 0) ? 0 : g-1];
                    r_slot_prio[g] <= r_slot_prio[(g == 0) ? 0 : g-1];
                end
            end else if (w_rem && (g < DEPTH-1)) begin
                r_slot_id[g]   <= r_slot_id[(g < DEPTH-1) ? g+1 : g];
                r_slot_prio[g] <= r_slot_prio[(g < DEPTH-1) ? g+1 : g];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ins)      n_count = r_count + CNT_W'(1);
        else if (w_rem) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else          r_count <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_occupancy <= n_count;
            o_out_id    <= '0;
            o_out_prio  <= '0;
            unique case (i_cmd.op)
                OP_INSERT: o_status <= ST_DONE;
                OP_REMOVE: begin
                    o_status   <= ST_DONE;
                    o_out_id   <= r_slot_id[0];
                    o_out_prio <= r_slot_prio[0];
                end
                OP_FULL:   o_status <= ST_FULL;
                OP_EMPTY:  o_status <= ST_EMPTY;
                default:   o_status <= ST_DONE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_slot_prio[0] >= r_slot_prio[1]))
        else $error("head slots out of priority order");
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("count not decremented on remove");

endmodule

[src/priority_ready_queue.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue
// Process ready queue kept sorted by priority, FIFO among equal priorities.
// ----------------------------------------------------------------------------
// Flow: an accepted request is latched, then executed into the result register
//   once that register is free or draining; the latch/exec sequencer handles one
//   request at a time, while a pending result may wait in its own register.
// Insert and remove compare and shift all slots in parallel.
// Reset: entry count and handshake state cleared; slot contents are not.
// ----------------------------------------------------------------------------
module priority_ready_queue import prq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8,
    parameter int PRIO_WIDTH  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_in_if.sink    i_item,
    prq_out_if.source o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_status w_status;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    prq_datapath #(
        .DEPTH  (QUEUE_DEPTH),
        .ID_W   (ID_WIDTH),
        .PRIO_W (PRIO_WIDTH),
        .CNT_W  (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_item.action),
        .i_proc_id   (i_item.proc_id),
        .i_prio      (i_item.prio),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_id    (o_result.out_id),
        .o_out_prio  (o_result.out_prio),
        .o_status    (w_status),
        .o_occupancy (o_result.occupancy)
    );

    assign o_result.status = w_status;

endmodule
